FILE: hw/rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types, codes and helpers for the point-in-polygon test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int COORD_BITS       = 32;
    localparam int DIFF_BITS        = COORD_BITS + 1;
    localparam int MAX_VERTICES_DEF = 256;

    // Operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [DIFF_BITS-1:0]   diff_t;
    typedef logic signed [2*DIFF_BITS-1:0] prod_t;

    typedef struct packed {
        logic [1:0] op;
        coord_t     coord_x;
        coord_t     coord_y;
    } cmd_t;

    typedef struct packed {
        logic       is_inside;
        logic [1:0] status;
    } result_t;

    // Control from the sequencer to the edge datapath
    typedef struct packed {
        logic load_point;
        logic load_seed;
        logic diff;
        logic mul_a;
        logic mul_b;
        logic tally;
    } edge_ctrl_t;

    function automatic diff_t widen(coord_t c);
        return diff_t'({c[COORD_BITS-1], c});
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Edge crossing datapath: differences, one shared signed multiplier and the
// exact product compare that toggles the crossing parity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_unit
    import pip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire edge_ctrl_t ctrl,
    input  wire coord_t     point_x,
    input  wire coord_t     point_y,
    input  wire coord_t     vert_x,
    input  wire coord_t     vert_y,
    output logic            parity
);

    coord_t px_reg;
    coord_t py_reg;
    coord_t xj_reg;
    coord_t yj_reg;
    diff_t  lhs_reg;
    diff_t  d_reg;
    diff_t  dx_reg;
    diff_t  ry_reg;
    logic   dpos_reg;
    prod_t  pa_reg;
    prod_t  pb_reg;
    logic   cross_reg;
    logic   parity_reg;

    diff_t  lhs_next;
    diff_t  d_next;
    diff_t  dx_next;
    diff_t  ry_next;
    logic   cross_next;
    logic   dpos_next;
    diff_t  mul_lhs;
    diff_t  mul_rhs;
    prod_t  product;
    logic   hit;

    always_comb
    begin
        lhs_next   = widen(px_reg) - widen(vert_x);
        d_next     = widen(yj_reg) - widen(vert_y);
        dx_next    = widen(xj_reg) - widen(vert_x);
        ry_next    = widen(py_reg) - widen(vert_y);
        cross_next = (vert_y > py_reg) != (yj_reg > py_reg);
        dpos_next  = yj_reg > vert_y;
    end

    // Shared multiplier: first pass lhs*d, second pass dx*(y - yi)
    always_comb
    begin
        mul_lhs = ctrl.mul_a ? lhs_reg : dx_reg;
        mul_rhs = ctrl.mul_a ? d_reg : ry_reg;
        product = mul_lhs * mul_rhs;
    end

    assign hit = dpos_reg ? (pa_reg < pb_reg) : (pb_reg < pa_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_point)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if (ctrl.load_seed)
        begin
            xj_reg <= vert_x;
            yj_reg <= vert_y;
        end
        if (ctrl.diff)
        begin
            lhs_reg  <= lhs_next;
            d_reg    <= d_next;
            dx_reg   <= dx_next;
            ry_reg   <= ry_next;
            dpos_reg <= dpos_next;
            xj_reg   <= vert_x;
            yj_reg   <= vert_y;
        end
        if (ctrl.mul_a)
        begin
            pa_reg <= product;
        end
        if (ctrl.mul_b)
        begin
            pb_reg <= product;
        end
    end

    // Tally reads the previous edge's flags while a new edge loads them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_reg  <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load_seed)
            begin
                cross_reg <= 1'b0;
            end
            else if (ctrl.diff)
            begin
                cross_reg <= cross_next;
            end
            if (ctrl.load_point)
            begin
                parity_reg <= 1'b0;
            end
            else if (ctrl.tally && cross_reg && hit)
            begin
                parity_reg <= ~parity_reg;
            end
        end
    end

    assign parity = parity_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Vertex table with crossing-parity point-in-polygon queries.
// Add, unused codes, and close or query on an empty table: result strobe in
// the cycle after the transaction, and a new transaction can follow at once.
// Close and query on n vertices: busy is high through the seed read and seed
// states, then diff, multiply A and multiply B on the shared multiplier for
// each edge, then finish and report. The receiver cannot stall the strobe.
// Reset clears the vertex count and closing flag; the table is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire cmd_t    cmd,
    output logic         done,
    output result_t      result
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_RD,
        S_SEED,
        S_DIFF,
        S_MUL_A,
        S_MUL_B,
        S_FINISH,
        S_REPORT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   rd_addr_reg;
    logic [CNT_W-1:0]   rd_addr_next;
    logic               flag_reg;
    logic               flag_next;
    logic               is_close_reg;
    logic               is_close_next;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;

    coord_t             mem_x [MAX_VERTICES];
    coord_t             mem_y [MAX_VERTICES];
    coord_t             rd_x_reg;
    coord_t             rd_y_reg;

    logic               accept;
    logic               full;
    logic               empty;
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   last_idx;
    logic [CNT_W-1:0]   rd_addr_inc;
    edge_ctrl_t         ctrl;
    logic               parity;

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign full        = (count_reg == CNT_W'(MAX_VERTICES));
    assign empty       = (count_reg == '0);
    assign last_idx    = count_reg - CNT_W'(1);
    assign rd_addr_inc = rd_addr_reg + CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_addr_next  = rd_addr_reg;
        flag_next     = flag_reg;
        is_close_next = is_close_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ctrl          = '0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_idx        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        OP_ADD:
                        begin
                            done_next   = 1'b1;
                            result_next = '{is_inside: 1'b0,
                                            status: (full ? ST_FULL : ST_OK)};
                            if (!full)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_CLOSE, OP_QUERY:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                result_next = '{is_inside: 1'b0, status: ST_EMPTY};
                                if (cmd.op == OP_CLOSE)
                                begin
                                    flag_next = 1'b1;
                                end
                            end
                            else
                            begin
                                ctrl.load_point = 1'b1;
                                is_close_next   = (cmd.op == OP_CLOSE);
                                state_next      = S_SEED_RD;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{is_inside: 1'b0, status: ST_OK};
                        end
                    endcase
                end
            end
            S_SEED_RD:
            begin
                // fetch the last vertex as the far end of the first edge
                rd_en      = 1'b1;
                rd_idx     = last_idx[IDX_W-1:0];
                state_next = S_SEED;
            end
            S_SEED:
            begin
                ctrl.load_seed = 1'b1;
                rd_en          = 1'b1;
                rd_idx         = '0;
                rd_addr_next   = '0;
                state_next     = S_DIFF;
            end
            S_DIFF:
            begin
                ctrl.diff  = 1'b1;
                ctrl.tally = 1'b1;
                state_next = S_MUL_A;
            end
            S_MUL_A:
            begin
                // prefetch the next vertex while the multiplier runs
                ctrl.mul_a   = 1'b1;
                rd_en        = 1'b1;
                rd_idx       = rd_addr_inc[IDX_W-1:0];
                rd_addr_next = rd_addr_inc;
                state_next   = S_MUL_B;
            end
            S_MUL_B:
            begin
                ctrl.mul_b = 1'b1;
                state_next = (rd_addr_reg == count_reg) ? S_FINISH : S_DIFF;
            end
            S_FINISH:
            begin
                ctrl.tally = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                done_next = 1'b1;
                if (is_close_reg)
                begin
                    result_next = '{is_inside: parity, status: ST_OK};
                    flag_next   = ~parity;
                end
                else
                begin
                    result_next = '{is_inside: parity ^ flag_reg, status: ST_OK};
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_addr_reg  <= '0;
            flag_reg     <= 1'b0;
            is_close_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_addr_reg  <= rd_addr_next;
            flag_reg     <= flag_next;
            is_close_reg <= is_close_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Vertex table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= cmd.coord_x;
            mem_y[count_reg[IDX_W-1:0]] <= cmd.coord_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_idx];
            rd_y_reg <= mem_y[rd_idx];
        end
    end

    pip_edge_unit u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .point_x (cmd.coord_x),
        .point_y (cmd.coord_y),
        .vert_x  (rd_x_reg),
        .vert_y  (rd_y_reg),
        .parity  (parity)
    );

    assign done   = done_reg;
    assign result = result_reg;

    a_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy && done))
        else $error("result strobe while a walk is in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond table depth");

    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !empty && (cmd.op == OP_CLOSE || cmd.op == OP_QUERY)
        |=> state_reg == S_SEED_RD)
        else $error("close or query on a filled table did not start a walk");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(accept) || $past(state_reg == S_REPORT)))
        else $error("result strobe without a transaction or finished walk");

endmodule

`default_nettype wire

FILE: verif/tb_point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test
// Self-checking bench for the point-in-polygon block. A tracker class keeps
// its own vertex table and closing flag, works out the answer of every
// accepted command with exact wide-integer edge tests, and compares each
// strobed result against the oldest pending answer. Stimulus runs a directed
// pass, random phases with varying sender gaps on a small polygon, and a
// final pass that fills the vertex table past full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_in_polygon_test;
    import pip_pkg::*;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam coord_t     COORD_MAX   = 32'sh7FFF_FFFF;
    localparam coord_t     COORD_MIN   = 32'sh8000_0000;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         SMALL_CAP   = 40;

    // Mirror of the vertex table and the answers still owed by the block
    class polygon_tracker;
        coord_t  vx [MAX_VERTICES_DEF];
        coord_t  vy [MAX_VERTICES_DEF];
        int      n_vertices;
        bit      region_inverted;
        result_t awaited_answers[$];
        int      n_errors;

        function new();
            n_vertices      = 0;
            region_inverted = 0;
            n_errors        = 0;
        endfunction

        // Parity of crossings of a ray from (px, py) toward +x
        function bit ray_parity(coord_t px, coord_t py);
            logic signed [69:0] xi, yi, xj, yj, qx, qy, rise, run, lhs, rhs;
            bit odd;
            bit hit;
            int i;
            int j;
            odd = 0;
            if (n_vertices == 0)
                return 0;
            qx = px;
            qy = py;
            j  = n_vertices - 1;
            for (i = 0; i < n_vertices; i++)
            begin
                if ((vy[i] > py) != (vy[j] > py))
                begin
                    xi   = vx[i];
                    yi   = vy[i];
                    xj   = vx[j];
                    yj   = vy[j];
                    rise = yj - yi;
                    run  = xj - xi;
                    lhs  = (qx - xi) * rise;
                    rhs  = run * (qy - yi);
                    hit  = (rise > 0) ? (lhs < rhs) : (rhs < lhs);
                    odd  = odd ^ hit;
                end
                j = i;
            end
            return odd;
        endfunction

        function void note_command(cmd_t c);
            result_t r;
            bit      p;
            r = '0;
            r.status = ST_OK;
            case (c.op)
                OP_ADD:
                begin
                    if (n_vertices < MAX_VERTICES_DEF)
                    begin
                        vx[n_vertices] = c.coord_x;
                        vy[n_vertices] = c.coord_y;
                        n_vertices++;
                    end
                    else
                        r.status = ST_FULL;
                end
                OP_CLOSE:
                begin
                    p               = ray_parity(c.coord_x, c.coord_y);
                    region_inverted = ~p;
                    r.is_inside     = p;
                    if (n_vertices == 0)
                        r.status = ST_EMPTY;
                end
                OP_QUERY:
                begin
                    if (n_vertices == 0)
                        r.status = ST_EMPTY;
                    else
                        r.is_inside = ray_parity(c.coord_x, c.coord_y) ^ region_inverted;
                end
                default: ;
            endcase
            // append at the tail
            awaited_answers = {awaited_answers, r};
        endfunction

        function void check_answer(result_t got);
            result_t want;
            if (awaited_answers.size() == 0)
            begin
                $display("%0t: result with nothing pending: is_inside %0d status %0d",
                         $time, got.is_inside, got.status);
                n_errors++;
                return;
            end
            want = awaited_answers.pop_front();
            if (got.is_inside !== want.is_inside)
            begin
                $display("%0t: is_inside mismatch: expected %0d actual %0d",
                         $time, want.is_inside, got.is_inside);
                n_errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
                n_errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    polygon_tracker sb;
    int             cycle_count;

    point_in_polygon_test #(
        .MAX_VERTICES (MAX_VERTICES_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sample the result strobe mid-cycle, away from the driving edge
    always @(negedge clk)
    begin
        if (rst_n && done)
            sb.check_answer(result);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[point_in_polygon_test] ERROR");
            $finish;
        end
    end

    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the command until busy is low at a rising edge
    task automatic send_cmd(logic [1:0] op, coord_t x, coord_t y);
        cmd_t c;
        c.op      = op;
        c.coord_x = x;
        c.coord_y = y;
        start <= 1'b1;
        cmd   <= c;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic drain_answers();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic coord_t pick_coord(bit axis_x);
        int unsigned sel;
        int          k;
        coord_t      base;
        sel = $urandom_range(99);
        if (sel < 55)
            return coord_t'(int'($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
        if (sel < 75 && sb.n_vertices > 0)
        begin
            k    = $urandom_range(sb.n_vertices - 1);
            base = axis_x ? sb.vx[k] : sb.vy[k];
            if (sel < 68)
                return base;
            return base + coord_t'(int'($urandom_range(2)) - 1);
        end
        if (sel < 88)
            return coord_t'($urandom);
        case ($urandom_range(3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    task automatic random_item(int idle_pct, int vertex_cap);
        int unsigned sel;
        logic [1:0]  op;
        sel = $urandom_range(99);
        if (sel < 18 && sb.n_vertices < vertex_cap)
            op = OP_ADD;
        else if (sel < 28)
            op = OP_CLOSE;
        else if (sel < 31)
            op = OP_SPARE;
        else
            op = OP_QUERY;
        while ($urandom_range(99) < idle_pct)
            idle_cycle();
        send_cmd(op, pick_coord(1'b1), pick_coord(1'b0));
    endtask

    initial
    begin
        int idle_plan[4];
        int phase;
        int k;

        idle_plan   = '{0, 57, 0, 6};
        sb          = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, unused code, then a square spanning the whole range
        send_cmd(OP_QUERY, '0, '0);
        send_cmd(OP_CLOSE, '0, '0);
        send_cmd(OP_QUERY, COORD_MAX, COORD_MIN);
        send_cmd(OP_SPARE, '0, '0);
        send_cmd(OP_ADD, COORD_MIN, COORD_MIN);
        send_cmd(OP_ADD, COORD_MAX, COORD_MIN);
        send_cmd(OP_ADD, COORD_MAX, COORD_MAX);
        send_cmd(OP_ADD, COORD_MIN, COORD_MAX);
        send_cmd(OP_QUERY, '0, '0);
        send_cmd(OP_CLOSE, '0, '0);
        send_cmd(OP_CLOSE, 32'sh0001_0000, -32'sh0001_0000);
        send_cmd(OP_QUERY, '0, '0);
        send_cmd(OP_QUERY, COORD_MAX, COORD_MAX);
        send_cmd(OP_QUERY, COORD_MIN, COORD_MIN);
        send_cmd(OP_QUERY, COORD_MAX, '0);
        send_cmd(OP_QUERY, COORD_MIN, '0);
        // Point level with a horizontal edge
        send_cmd(OP_QUERY, '0, COORD_MAX);
        send_cmd(OP_QUERY, '0, COORD_MIN);
        send_cmd(OP_SPARE, COORD_MIN, COORD_MAX);
        send_cmd(OP_CLOSE, COORD_MAX, COORD_MAX);
        send_cmd(OP_QUERY, -1, -1);
        drain_answers();

        for (phase = 0; phase < 4; phase++)
        begin
            for (k = 0; k < 65; k++)
                random_item(idle_plan[phase], SMALL_CAP);
            drain_answers();
        end

        // Fill the table, with a random command between adds on the growing polygon
        while (sb.n_vertices < MAX_VERTICES_DEF)
        begin
            random_item(6, MAX_VERTICES_DEF);
            if (sb.n_vertices < MAX_VERTICES_DEF)
                send_cmd(OP_ADD, pick_coord(1'b1), pick_coord(1'b0));
        end
        for (k = 0; k < 3; k++)
            send_cmd(OP_ADD, pick_coord(1'b1), pick_coord(1'b0));
        send_cmd(OP_CLOSE, pick_coord(1'b1), pick_coord(1'b0));
        for (k = 0; k < 4; k++)
            send_cmd(OP_QUERY, pick_coord(1'b1), pick_coord(1'b0));
        send_cmd(OP_SPARE, COORD_MAX, COORD_MIN);
        send_cmd(OP_ADD, COORD_MAX, COORD_MAX);

        drain_answers();
        repeat (20) @(posedge clk);
        if (sb.n_errors == 0)
            $display("[point_in_polygon_test] OK");
        else
            $display("[point_in_polygon_test] ERROR");
        $finish;
    end

endmodule
